[design/ggws_pkg.sv]
`timescale 1ns / 1ps
package ggws_pkg;

    localparam int HEIGHT_BITS = 23;
    localparam int COUNT_BITS  = 16;
    localparam int FLAG_BITS   = 5;
    localparam int OBJ_BITS    = 16;

    // Glyph flag bit positions.
    localparam int FLAG_SPACE    = 0;
    localparam int FLAG_GEN      = 1;
    localparam int FLAG_PUNCT    = 2;
    localparam int FLAG_COMBINE  = 3;
    localparam int FLAG_OBJVALID = 4;

    localparam logic KIND_GLYPH = 1'b0;
    localparam logic KIND_EOL   = 1'b1;

    // Break limit is gap * GAP_SCALE > num * H.
    localparam int NUM_W     = 9;
    localparam logic [NUM_W-1:0] NUM_BASE   = 9'd140;
    localparam logic [NUM_W-1:0] NUM_PUNCT  = 9'd182;
    localparam logic [NUM_W-1:0] NUM_CONSEC = 9'd210;
    localparam logic [NUM_W-1:0] NUM_BOTH   = 9'd273;
    localparam logic [NUM_W-1:0] GAP_SCALE  = 9'd400;

    // Insertion engine states.
    localparam logic [1:0] SRT_IDLE = 2'd0;
    localparam logic [1:0] SRT_RD   = 2'd1;
    localparam logic [1:0] SRT_CMP  = 2'd2;

endpackage

[design/glyph_gap_word_segmenter.sv]
`timescale 1ns / 1ps
// A closed word reaches m_valid via ST_MRD and ST_MCAP after an end-of-line or space item is
// accepted, or via ST_MUL, ST_CMP, ST_MRD and ST_MCAP after the glyph whose gap breaks it;
// ST_MCAP waits until the result register is free. One item at a time: s_ready is low from an
// accept through the gap test on an open word, any close and the sorted insert (ST_UPD, ST_INSW),
// where each store steps down one entry per SRT_RD/SRT_CMP pair until entry zero or a compare stops.
// Reset: synchronous, active low; clears word state, sets char_height to 3072, not store contents.
module glyph_gap_word_segmenter #(
    parameter int MAX_WORD_GLYPHS = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ggws_pkg::HEIGHT_BITS-1:0]      cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_kind,
    input  logic signed [COORD_BITS-1:0]          s_pen_x,
    input  logic signed [COORD_BITS-1:0]          s_box_left,
    input  logic signed [COORD_BITS-1:0]          s_box_right,
    input  logic signed [COORD_BITS-1:0]          s_box_bottom,
    input  logic signed [COORD_BITS-1:0]          s_box_top,
    input  logic signed [COORD_BITS-1:0]          s_baseline,
    input  logic [ggws_pkg::HEIGHT_BITS-1:0]      s_ink_size,
    input  logic [ggws_pkg::OBJ_BITS-1:0]         s_object_ref,
    input  logic [ggws_pkg::COUNT_BITS-1:0]       s_char_position,
    input  logic [ggws_pkg::FLAG_BITS-1:0]        s_glyph_flags,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [COORD_BITS-1:0]          m_word_left,
    output logic signed [COORD_BITS-1:0]          m_word_right,
    output logic signed [COORD_BITS-1:0]          m_word_bottom,
    output logic signed [COORD_BITS-1:0]          m_word_top,
    output logic signed [COORD_BITS-1:0]          m_word_baseline,
    output logic [ggws_pkg::HEIGHT_BITS-1:0]      m_word_height,
    output logic [ggws_pkg::COUNT_BITS-1:0]       m_glyph_count,
    output logic                                  m_median_truncated
);
    localparam int HB = ggws_pkg::HEIGHT_BITS;
    localparam int CB = ggws_pkg::COUNT_BITS;
    localparam int IW = $clog2(MAX_WORD_GLYPHS);
    localparam int GW = COORD_BITS + 1;
    // Product width: wide enough for gap*400 and for num*H as a positive signed value.
    localparam int PW = (COORD_BITS + 11 > 34) ? COORD_BITS + 11 : 34;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_MRD  = 3'd3;
    localparam logic [2:0] ST_MCAP = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;
    localparam logic [2:0] ST_INSW = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [HB-1:0] char_height_reg;

    // Latched item.
    logic                  kind_reg;
    logic [COORD_BITS-1:0] ox_reg, left_reg, right_reg, bottom_reg, top_reg, base_reg;
    logic [HB-1:0]         ink_reg;
    logic [ggws_pkg::OBJ_BITS-1:0] obj_reg;
    logic [CB-1:0]         pos_reg;
    logic [ggws_pkg::FLAG_BITS-1:0] flags_reg;

    // Line state.
    logic                  word_open_reg;
    logic [COORD_BITS-1:0] last_right_reg;
    logic [ggws_pkg::OBJ_BITS-1:0] last_obj_reg;
    logic                  last_obj_valid_reg;
    logic [CB-1:0]         last_pos_reg;
    logic [COORD_BITS-1:0] ub_left_reg, ub_right_reg, ub_bottom_reg, ub_top_reg;
    logic [CB-1:0]         count_reg;

    // Break compare operands.
    logic signed [PW-1:0]  gap_prod_reg, limit_reg;
    logic                  gap_neg_reg;

    // Result register.
    logic                  m_valid_reg;
    logic [COORD_BITS-1:0] o_left_reg, o_right_reg, o_bottom_reg, o_top_reg, o_base_reg;
    logic [HB-1:0]         o_height_reg;
    logic [CB-1:0]         o_count_reg;
    logic                  o_trunc_reg;

    logic s_fire;
    logic [GW-1:0] gap;
    logic consec, punct;
    logic [ggws_pkg::NUM_W-1:0] num;
    logic [IW:0]   n_med;
    logic [IW-1:0] mid;
    logic          store_room;
    logic          ins_start;
    logic          base_busy, ht_busy;
    logic [COORD_BITS-1:0] base_med;
    logic [HB-1:0]         ht_med;
    logic          out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // The gap is formed one bit wider so the subtraction cannot wrap.
    assign gap = {ox_reg[COORD_BITS-1], ox_reg} - {last_right_reg[COORD_BITS-1], last_right_reg};

    assign consec = flags_reg[ggws_pkg::FLAG_OBJVALID] && last_obj_valid_reg &&
                    (obj_reg == last_obj_reg) &&
                    ({1'b0, pos_reg} == {1'b0, last_pos_reg} + {{CB{1'b0}}, 1'b1});
    assign punct  = flags_reg[ggws_pkg::FLAG_PUNCT];

    always_comb begin
        case ({consec, punct})
            2'b00:   num = ggws_pkg::NUM_BASE;
            2'b01:   num = ggws_pkg::NUM_PUNCT;
            2'b10:   num = ggws_pkg::NUM_CONSEC;
            default: num = ggws_pkg::NUM_BOTH;
        endcase
    end

    // Medians use element n/2 of the first min(count, MAX) sorted entries.
    assign n_med = (count_reg > CB'(MAX_WORD_GLYPHS)) ? (IW+1)'(MAX_WORD_GLYPHS)
                                                     : count_reg[IW:0];
    assign mid   = n_med[IW:1];

    assign store_room = (count_reg < CB'(MAX_WORD_GLYPHS));
    assign ins_start  = (state_reg == ST_UPD) && (!word_open_reg || store_room);

    // A new word always inserts at entry zero.
    ggws_sort_store #(.W(COORD_BITS), .SIGNED_VALS(1'b1), .DEPTH(MAX_WORD_GLYPHS)) u_base (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ins_start),
        .fill    (word_open_reg ? count_reg[IW-1:0] : {IW{1'b0}}),
        .value   (base_reg),
        .med_idx (mid),
        .busy    (base_busy),
        .rd_data (base_med)
    );

    ggws_sort_store #(.W(HB), .SIGNED_VALS(1'b0), .DEPTH(MAX_WORD_GLYPHS)) u_height (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ins_start),
        .fill    (word_open_reg ? count_reg[IW-1:0] : {IW{1'b0}}),
        .value   (ink_reg),
        .med_idx (mid),
        .busy    (ht_busy),
        .rd_data (ht_med)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_kind == ggws_pkg::KIND_EOL || s_glyph_flags[ggws_pkg::FLAG_SPACE]) begin
                        state_next = word_open_reg ? ST_MRD : ST_IDLE;
                    end else if (s_glyph_flags[ggws_pkg::FLAG_GEN]) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = word_open_reg ? ST_MUL : ST_UPD;
                    end
                end
            end
            ST_MUL: state_next = ST_CMP;
            ST_CMP: begin
                if (!(flags_reg[ggws_pkg::FLAG_COMBINE] && gap_neg_reg) &&
                    (gap_prod_reg > limit_reg)) begin
                    state_next = ST_MRD;
                end else begin
                    state_next = ST_UPD;
                end
            end
            ST_MRD: state_next = ST_MCAP;
            ST_MCAP: begin
                if (out_free) begin
                    state_next = (kind_reg == ggws_pkg::KIND_GLYPH &&
                                  !flags_reg[ggws_pkg::FLAG_SPACE]) ? ST_UPD : ST_IDLE;
                end
            end
            ST_UPD: state_next = ST_INSW;
            ST_INSW: begin
                if (!base_busy && !ht_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            char_height_reg    <= HB'(3072);
            word_open_reg      <= 1'b0;
            last_right_reg     <= '0;
            last_obj_reg       <= '0;
            last_obj_valid_reg <= 1'b0;
            last_pos_reg       <= '0;
            count_reg          <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                char_height_reg <= cfg_data;
            end
            if (state_reg == ST_MCAP && out_free) begin
                m_valid_reg   <= 1'b1;
                word_open_reg <= 1'b0;
                count_reg     <= '0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_UPD) begin
                word_open_reg      <= 1'b1;
                last_right_reg     <= right_reg;
                last_obj_reg       <= obj_reg;
                last_obj_valid_reg <= flags_reg[ggws_pkg::FLAG_OBJVALID];
                last_pos_reg       <= pos_reg;
                if (!word_open_reg) begin
                    count_reg <= CB'(1);
                end else if (count_reg != {CB{1'b1}}) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // Item capture, break operands, union box and result payload.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg   <= s_kind;
            ox_reg     <= s_pen_x;
            left_reg   <= s_box_left;
            right_reg  <= s_box_right;
            bottom_reg <= s_box_bottom;
            top_reg    <= s_box_top;
            base_reg   <= s_baseline;
            ink_reg    <= s_ink_size;
            obj_reg    <= s_object_ref;
            pos_reg    <= s_char_position;
            flags_reg  <= s_glyph_flags;
        end
        if (state_reg == ST_MUL) begin
            gap_neg_reg  <= gap[GW-1];
            gap_prod_reg <= $signed({{(PW-GW){gap[GW-1]}}, gap}) *
                            $signed({{(PW-ggws_pkg::NUM_W){1'b0}}, ggws_pkg::GAP_SCALE});
            limit_reg    <= $signed({{(PW-HB){1'b0}}, char_height_reg}) *
                            $signed({{(PW-ggws_pkg::NUM_W){1'b0}}, num});
        end
        if (state_reg == ST_UPD) begin
            if (!word_open_reg) begin
                ub_left_reg   <= left_reg;
                ub_right_reg  <= right_reg;
                ub_bottom_reg <= bottom_reg;
                ub_top_reg    <= top_reg;
            end else begin
                if ($signed(left_reg) < $signed(ub_left_reg))     ub_left_reg   <= left_reg;
                if ($signed(right_reg) > $signed(ub_right_reg))   ub_right_reg  <= right_reg;
                if ($signed(bottom_reg) < $signed(ub_bottom_reg)) ub_bottom_reg <= bottom_reg;
                if ($signed(top_reg) > $signed(ub_top_reg))       ub_top_reg    <= top_reg;
            end
        end
        if (state_reg == ST_MCAP && out_free) begin
            o_left_reg   <= ub_left_reg;
            o_right_reg  <= ub_right_reg;
            o_bottom_reg <= ub_bottom_reg;
            o_top_reg    <= ub_top_reg;
            o_base_reg   <= base_med;
            o_height_reg <= ht_med;
            o_count_reg  <= count_reg;
            o_trunc_reg  <= (count_reg > CB'(MAX_WORD_GLYPHS));
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_word_left        = o_left_reg;
    assign m_word_right       = o_right_reg;
    assign m_word_bottom      = o_bottom_reg;
    assign m_word_top         = o_top_reg;
    assign m_word_baseline    = o_base_reg;
    assign m_word_height      = o_height_reg;
    assign m_glyph_count      = o_count_reg;
    assign m_median_truncated = o_trunc_reg;

endmodule

[design/ggws_sort_store.sv]
`timescale 1ns / 1ps
module ggws_sort_store #(
    parameter int W = 24,
    parameter bit SIGNED_VALS = 1'b1,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [$clog2(DEPTH)-1:0] fill,
    input  logic [W-1:0]             value,
    input  logic [$clog2(DEPTH)-1:0] med_idx,
    output logic                     busy,
    output logic [W-1:0]             rd_data
);
    localparam int IW = $clog2(DEPTH);

    logic [W-1:0]  mem [DEPTH];
    logic [W-1:0]  rdata_reg;
    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [W-1:0]  val_reg, val_next;
    logic [IW-1:0] rd_addr;
    logic          we;
    logic [IW-1:0] waddr;
    logic [W-1:0]  wdata;
    logic [W-1:0]  key_a, key_b;

    // Flipping the sign bit turns a signed order into an unsigned one.
    assign key_a = {rdata_reg[W-1] ^ SIGNED_VALS, rdata_reg[W-2:0]};
    assign key_b = {val_reg[W-1] ^ SIGNED_VALS, val_reg[W-2:0]};

    assign rd_addr = (state_reg == ggws_pkg::SRT_IDLE) ? med_idx : idx_reg - 1'b1;
    assign busy    = (state_reg != ggws_pkg::SRT_IDLE);
    assign rd_data = rdata_reg;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = val_reg;
        case (state_reg)
            ggws_pkg::SRT_IDLE: begin
                if (start) begin
                    idx_next   = fill;
                    val_next   = value;
                    state_next = ggws_pkg::SRT_RD;
                end
            end
            ggws_pkg::SRT_RD: begin
                if (idx_reg == '0) begin
                    we         = 1'b1;
                    state_next = ggws_pkg::SRT_IDLE;
                end else begin
                    state_next = ggws_pkg::SRT_CMP;
                end
            end
            ggws_pkg::SRT_CMP: begin
                we = 1'b1;
                if (key_a > key_b) begin
                    wdata      = rdata_reg;
                    idx_next   = idx_reg - 1'b1;
                    state_next = ggws_pkg::SRT_RD;
                end else begin
                    state_next = ggws_pkg::SRT_IDLE;
                end
            end
            default: state_next = ggws_pkg::SRT_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ggws_pkg::SRT_IDLE;
        end else begin
            state_reg <= state_next;
        end
        idx_reg <= idx_next;
        val_reg <= val_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
    end

endmodule
